FILE: hdl/dna_marker_text_encoder_top_assert.svh
// Assertion macros for the DNA marker text encoder.
`ifndef DNA_MARKER_TEXT_ENCODER_TOP_ASSERT_SVH
`define DNA_MARKER_TEXT_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DMTE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DMTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dmte_pkg.sv
// Shared types, constants and helpers of the DNA marker text encoder.
package dmte_pkg;

    localparam int VALUE_W = 64;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [2:0] {
        BASE_NONE = 3'd0,
        BASE_A    = 3'd1,
        BASE_C    = 3'd2,
        BASE_G    = 3'd3,
        BASE_T    = 3'd4
    } t_base;

    // One queued transaction: an optional marker, then an optional base.
    typedef struct packed {
        logic               has_marker;
        logic [VALUE_W-1:0] marker;
        logic               has_base;
        t_base              base;
        logic               last;
    } t_entry;

    function automatic t_base base_code(input logic [7:0] b);
        t_base code;
        case (b)
            8'h41, 8'h61: code = BASE_A;
            8'h43, 8'h63: code = BASE_C;
            8'h47, 8'h67: code = BASE_G;
            8'h54, 8'h74: code = BASE_T;
            default:      code = BASE_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/dmte_front.sv
// Front end: classifies text bytes, builds marker numbers, forms queue entries.
module dmte_front
    import dmte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_stream_end,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [VALUE_W-1:0] r_accum, n_accum;
    logic               r_pending, n_pending;

    t_base              code;
    logic               is_digit;
    logic [3:0]         digit;
    logic [VALUE_W-1:0] accum_step;

    always_comb begin
        code       = base_code(i_text_byte);
        is_digit   = (i_text_byte >= CHAR_ZERO) && (i_text_byte <= CHAR_NINE);
        digit      = 4'(i_text_byte - CHAR_ZERO);
        // acc*10 as (acc<<3)+(acc<<1), wraps mod 2^64
        accum_step = (r_accum << 3) + (r_accum << 1) + VALUE_W'(digit);

        n_accum   = r_accum;
        n_pending = r_pending;
        o_entry.has_marker = 1'b0;
        o_entry.marker     = r_accum;
        o_entry.has_base   = 1'b0;
        o_entry.base       = code;
        o_entry.last       = i_stream_end;

        if (code != BASE_NONE) begin
            o_entry.has_marker = r_pending;
            o_entry.has_base   = 1'b1;
            n_accum   = '0;
            n_pending = 1'b0;
        end else if (is_digit) begin
            if (i_stream_end) begin
                o_entry.has_marker = 1'b1;
                o_entry.marker     = accum_step;
                n_accum   = '0;
                n_pending = 1'b0;
            end else begin
                n_accum   = accum_step;
                n_pending = 1'b1;
            end
        end else if (i_stream_end) begin
            o_entry.has_marker = r_pending;
            n_accum   = '0;
            n_pending = 1'b0;
        end

        o_push = i_accept && (o_entry.has_marker || o_entry.has_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_accum   <= n_accum;
            r_pending <= n_pending;
        end
    end

endmodule

FILE: hdl/dmte_fifo.sv
// Short entry queue between front and back end.
module dmte_fifo
    import dmte_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/dmte_back.sv
// Back end: expands queued entries into one or two result transactions.
module dmte_back
    import dmte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fifo_empty,
    input  t_entry             i_fifo_entry,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_symbol_value,
    output logic               o_is_marker,
    output logic               o_run_last,
    output logic               o_final_symbol
);

    t_entry r_entry;
    logic   r_busy;
    logic   r_marker_phase;
    logic   fire;
    logic   finishing;

    assign o_valid        = r_busy;
    assign o_is_marker    = r_marker_phase;
    assign o_symbol_value = r_marker_phase ? r_entry.marker
                                           : VALUE_W'(r_entry.base);
    assign o_run_last     = !(r_marker_phase && r_entry.has_base);
    assign o_final_symbol = o_run_last && r_entry.last;

    assign fire      = r_busy && i_ready;
    assign finishing = fire && o_run_last;
    assign o_pop     = !i_fifo_empty && (!r_busy || finishing);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_fifo_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_marker_phase <= 1'b0;
        end else if (o_pop) begin
            r_busy         <= 1'b1;
            r_marker_phase <= i_fifo_entry.has_marker;
        end else if (finishing) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            // marker delivered, base follows
            r_marker_phase <= 1'b0;
        end
    end

endmodule

FILE: hdl/dna_marker_text_encoder_top.sv
// Top level of the DNA marker text encoder.
//
// Input channel (i_valid/o_ready) takes one text byte per transaction, with
// i_stream_end on the final byte. Bases A/C/G/T (any case) give symbols 1..4;
// runs of digits build one 64-bit marker number (wrapping), delivered before
// the next base or on the stream end. Other bytes are skipped.
// Output channel (o_valid/i_ready) gives one result per transaction, with
// o_run_last on the last result of an input byte and o_final_symbol on the
// last result of a stream.
// A result passes through the queue and then the output register after its
// byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; a byte giving a marker and a base holds the output for
// both of its results. The single output register sets this rate.
// Bytes that give no result never enter the queue.
// Reset clears the marker state and empties the queue. When the receiver
// stalls, results wait in the output register and the queue; o_ready drops
// once the queue is full.
module dna_marker_text_encoder_top
    import dmte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_stream_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_symbol_value,
    output logic               o_is_marker,
    output logic               o_run_last,
    output logic               o_final_symbol
);

    `include "dna_marker_text_encoder_top_assert.svh"

    logic   accept;
    logic   push;
    logic   pop;
    logic   fifo_full;
    logic   fifo_empty;
    t_entry push_entry;
    t_entry head_entry;

    assign o_ready = !fifo_full;
    assign accept  = i_valid && o_ready;

    dmte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_stream_end (i_stream_end),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    dmte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    dmte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_empty   (fifo_empty),
        .i_fifo_entry   (head_entry),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_symbol_value (o_symbol_value),
        .o_is_marker    (o_is_marker),
        .o_run_last     (o_run_last),
        .o_final_symbol (o_final_symbol)
    );

    `DMTE_ASSERT_IMPL(a_base_code, o_valid && !o_is_marker,
        o_run_last && o_symbol_value >= 64'd1 && o_symbol_value <= 64'd4,
        "base result out of range or not last of its byte")
    `DMTE_ASSERT_IMPL(a_final_is_last, o_valid && o_final_symbol, o_run_last,
        "final symbol without run_last")
    `DMTE_ASSERT_NEXT(a_base_follows, o_valid && i_ready && !o_run_last,
        o_valid && !o_is_marker, "marker not followed by its base")

endmodule

FILE: bench/tb_dna_marker_text_encoder_top.sv
// Self-checking testbench for the DNA marker text encoder: directed and random text streams.
module tb_dna_marker_text_encoder_top;
    import dmte_pkg::*;

    localparam int NUM_USEFUL  = 900;
    localparam int STALL_LIMIT = 2000;
    localparam int CALM_TAIL   = 120;

    typedef struct packed {
        logic [7:0] text;
        logic       eos;
    } t_text_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               marker;
        logic               run_last;
        logic               final_sym;
    } t_symbol;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_text_byte = 8'h00;
    logic               i_stream_end = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [VALUE_W-1:0] o_symbol_value;
    logic               o_is_marker;
    logic               o_run_last;
    logic               o_final_symbol;

    t_text_item         text_queue[$];
    t_symbol            symbol_queue[$];
    logic [VALUE_W-1:0] marker_acc = '0;
    logic               marker_open = 1'b0;
    logic               idle_on = 1'b0;
    int                 sent_cnt = 0;
    int                 total_items = 0;
    int                 useful_cnt = 0;
    int                 err_cnt = 0;
    int                 src_gap = 0;
    int                 sink_gap = 0;
    int                 stall_cycles = 0;

    // Letters picked for random bases, one per byte lane.
    localparam logic [63:0] BASE_LETTERS = "ACGTacgt";

    dna_marker_text_encoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_stream_end   (i_stream_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_symbol_value (o_symbol_value),
        .o_is_marker    (o_is_marker),
        .o_run_last     (o_run_last),
        .o_final_symbol (o_final_symbol)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_base base_of(input logic [7:0] b);
        t_base code;
        case (b)
            "A", "a": code = BASE_A;
            "C", "c": code = BASE_C;
            "G", "g": code = BASE_G;
            "T", "t": code = BASE_T;
            default:  code = BASE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // Expected symbols for one accepted byte; updates the marker state.
    function automatic void encode_byte(input logic [7:0] b, input logic eos);
        t_symbol outs[$];
        t_symbol sym;
        t_base   code;
        code = base_of(b);
        if (code != BASE_NONE) begin
            if (marker_open) begin
                outs.insert(outs.size(), '{value: marker_acc, marker: 1'b1, run_last: 1'b0,
                                           final_sym: 1'b0});
                marker_acc  = '0;
                marker_open = 1'b0;
            end
            outs.insert(outs.size(), '{value: VALUE_W'(code), marker: 1'b0, run_last: 1'b0,
                                       final_sym: 1'b0});
        end else if (is_digit(b)) begin
            marker_acc  = marker_acc * 10 + VALUE_W'(b - CHAR_ZERO);
            marker_open = 1'b1;
        end
        if (eos && marker_open) begin
            outs.insert(outs.size(), '{value: marker_acc, marker: 1'b1, run_last: 1'b0,
                                       final_sym: 1'b0});
            marker_acc  = '0;
            marker_open = 1'b0;
        end
        if (outs.size() > 0) begin
            sym = outs[outs.size()-1];
            sym.run_last  = 1'b1;
            sym.final_sym = eos;
            outs[outs.size()-1] = sym;
        end
        foreach (outs[k]) symbol_queue.insert(symbol_queue.size(), outs[k]);
    endfunction

    task automatic add_item(input logic [7:0] b, input logic eos);
        text_queue.insert(text_queue.size(), '{text: b, eos: eos});
        if (eos || is_digit(b) || base_of(b) != BASE_NONE)
            useful_cnt++;
    endtask

    function automatic logic [7:0] rand_base();
        return BASE_LETTERS[8*$urandom_range(0, 7) +: 8];
    endfunction

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Driver: presents pending bytes, predicts on each accepted transaction.
    always @(posedge i_clk) begin
        logic accepted;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_text_byte  <= 8'h00;
            i_stream_end <= 1'b0;
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) begin
                encode_byte(i_text_byte, i_stream_end);
                void'(text_queue.pop_front());
                sent_cnt++;
            end
            idle_on <= (sent_cnt < total_items - CALM_TAIL) && ((sent_cnt / 150) % 4 != 3);
            if (i_valid && !accepted) begin
                // hold until taken
            end else if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (text_queue.size() == 0) begin
                i_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                src_gap = $urandom_range(0, 3);
                i_valid <= 1'b0;
            end else begin
                i_valid      <= 1'b1;
                i_text_byte  <= text_queue[0].text;
                i_stream_end <= text_queue[0].eos;
            end
        end
    end

    // Monitor: checks each output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_symbol exp_sym;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (symbol_queue.size() == 0) begin
                    $error("unexpected result: symbol_value %0h is_marker %0b",
                           o_symbol_value, o_is_marker);
                    err_cnt++;
                end else begin
                    exp_sym = symbol_queue.pop_front();
                    if (o_symbol_value !== exp_sym.value) begin
                        $error("symbol_value: expected %0h, got %0h",
                               exp_sym.value, o_symbol_value);
                        err_cnt++;
                    end
                    if (o_is_marker !== exp_sym.marker) begin
                        $error("is_marker: expected %0b, got %0b",
                               exp_sym.marker, o_is_marker);
                        err_cnt++;
                    end
                    if (o_run_last !== exp_sym.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               exp_sym.run_last, o_run_last);
                        err_cnt++;
                    end
                    if (o_final_symbol !== exp_sym.final_sym) begin
                        $error("final_symbol: expected %0b, got %0b",
                               exp_sym.final_sym, o_final_symbol);
                        err_cnt++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          sel;
        int          len;
        logic [7:0]  b;
        // Directed: every base in both cases
        add_item("A", 1'b0);
        add_item("c", 1'b0);
        add_item("G", 1'b0);
        add_item("t", 1'b0);
        add_item("a", 1'b0);
        add_item("C", 1'b0);
        add_item("g", 1'b0);
        add_item("T", 1'b0);
        // digits split by a skipped byte join into one marker, flushed before a base
        add_item("1", 1'b0);
        add_item(8'h00, 1'b0);
        add_item("2", 1'b0);
        add_item("5", 1'b0);
        add_item("G", 1'b0);
        // marker zero flushed by the stream end
        add_item("0", 1'b1);
        // marker then base on the final byte: two results
        add_item("7", 1'b0);
        add_item("A", 1'b1);
        // empty end
        add_item("Z", 1'b1);
        // skipped byte on the end flushes the pending marker
        add_item("9", 1'b0);
        add_item(8'hFF, 1'b1);
        // overflow: 22 nines wrap past 2^64
        for (int k = 0; k < 22; k++) add_item("9", k == 21);

        useful_cnt = 0;
        while (useful_cnt < NUM_USEFUL) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                // noise
                add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else if (sel < 18) begin
                // broken: digits laced with noise, ending abruptly
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                    : rand_digit();
                    add_item(b, (k == len - 1) && $urandom_range(0, 1));
                end
            end else begin
                // optional marker followed by bases
                if ($urandom_range(0, 3) != 0) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 26)
                                                      : $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) add_item(rand_digit(), 1'b0);
                end
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    add_item(rand_base(), (k == len - 1) && ($urandom_range(0, 9) == 0));
            end
        end
        total_items = text_queue.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (symbol_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (symbol_queue.size() != 0) begin
            $error("%0d expected results never arrived", symbol_queue.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dmte_pkg.sv
hdl/dmte_front.sv
hdl/dmte_fifo.sv
hdl/dmte_back.sv
hdl/dna_marker_text_encoder_top.sv
bench/tb_dna_marker_text_encoder_top.sv
